@@ rtl/core/fvn_pkg.sv @@
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, constants and helper functions of the fractal value noise
// pipeline: hash mixer constants, job tag, fixed-point blend helpers and the
// normalization reciprocal table.
// ----------------------------------------------------------------------------
package fvn_pkg;

  // Default parameter values.
  localparam int DEF_MAX_OCTAVES = 8;
  localparam int DEF_FRAC_BITS   = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 8'd1;

  // Hash mixer multipliers and per-axis offsets.
  localparam logic [31:0] MIX_C1    = 32'h7feb352d;
  localparam logic [31:0] MIX_C2    = 32'h846ca68b;
  localparam logic [31:0] OFF_X     = 32'h9e3779b9;
  localparam logic [31:0] OFF_Y     = 32'h85ebca6b;
  localparam logic [31:0] OFF_Z     = 32'hc2b2ae35;
  localparam logic [2:0][31:0] AXIS_OFF = {OFF_Z, OFF_Y, OFF_X};
  localparam logic [31:0] SEED_STEP = 32'd1013;

  // Smoothstep constant 3.0 in Q.16, and the corner value bias 1.0 in Q.16.
  localparam logic [17:0] WGT_K3    = 18'd196608;
  localparam logic [17:0] CVAL_BIAS = 18'd65536;

  // Fraction bits of the normalization reciprocal.
  localparam int RECIP_W = 24;

  // Octave index / count width (up to 16 octaves).
  localparam int OCT_W = 5;

  // Blend product width: 19-bit difference times 18-bit signed weight.
  localparam int BPROD_W = 37;

  typedef logic signed [17:0] cval_t;
  typedef logic [16:0]        wgt_t;
  typedef logic signed [BPROD_W-1:0] bprod_t;

  // Tag that travels with every octave job.
  typedef struct packed {
    logic [OCT_W-1:0] k;
    logic             first;
    logic             last;
    logic             zero;
    logic [OCT_W-1:0] n;
  } tag_t;

  function automatic logic [31:0] xs16(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [31:0] xs15(input logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

  // (b - a) * w, exact.
  function automatic bprod_t mul_diff(input cval_t a, input cval_t b, input wgt_t w);
    logic signed [18:0] d;
    d = 19'(b) - 19'(a);
    return d * $signed({1'b0, w});
  endfunction

  // a + round_half_up(p / 2^16).
  function automatic cval_t blend_fin(input cval_t a, input bprod_t p);
    bprod_t r;
    r = (p + 37'sd32768) >>> 16;
    return a + cval_t'(r[17:0]);
  endfunction

  // round(2^24 * 2^(n-1) / (2^n - 1)).
  function automatic logic [RECIP_W:0] recip(input logic [OCT_W-1:0] n);
    logic [RECIP_W:0] r;
    case (n)
      5'd1:    r = 25'd16777216;
      5'd2:    r = 25'd11184811;
      5'd3:    r = 25'd9586981;
      5'd4:    r = 25'd8947849;
      5'd5:    r = 25'd8659208;
      5'd6:    r = 25'd8521761;
      5'd7:    r = 25'd8454660;
      5'd8:    r = 25'd8421505;
      5'd9:    r = 25'd8405024;
      5'd10:   r = 25'd8396808;
      5'd11:   r = 25'd8392706;
      5'd12:   r = 25'd8390657;
      5'd13:   r = 25'd8389632;
      5'd14:   r = 25'd8389120;
      5'd15:   r = 25'd8388864;
      5'd16:   r = 25'd8388736;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/fvn_hash.sv @@
// ----------------------------------------------------------------------------
// fvn_hash
// Five-stage corner hash pipeline. Mixes the six axis coordinates, combines
// them into eight corner hashes with the octave salt, and maps each hash to a
// corner value. The smoothstep weights are computed alongside.
// ----------------------------------------------------------------------------
module fvn_hash import fvn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0][31:0]  in_cell,
  input  logic [2:0][15:0]  in_frac,
  input  logic [31:0]       in_salt,
  input  tag_t              in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output cval_t [7:0]       out_cval,
  output wgt_t  [2:0]       out_wgt,
  output tag_t              out_tag
);

  localparam int NST = 5;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  // Stage registers.
  logic [5:0][31:0] p1_r, p2_r;
  logic [2:0][31:0] tt_r;
  logic [2:0][17:0] t3_r;
  logic [2:0][49:0] wp_r;
  logic [31:0]      salt0_r, salt1_r;
  logic [7:0][31:0] q1_r, q2_r;
  wgt_t [2:0]       w2_r, w3_r, w4_r;
  cval_t [7:0]      cv_r;
  tag_t             tag0_r, tag1_r, tag2_r, tag3_r, tag4_r;

  logic [5:0][31:0] p1_nxt, p2_nxt, mm;
  logic [2:0][31:0] tt_nxt;
  logic [2:0][17:0] t3_nxt;
  logic [2:0][49:0] wp_nxt;
  logic [7:0][31:0] q1_nxt, q2_nxt;
  wgt_t [2:0]       w2_nxt;
  cval_t [7:0]      cv_nxt;

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 0: axis offset, first mixer round; weight square and 3 - 2t factor.
  always_comb begin
    logic [31:0] av;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 2; b++) begin
        av = in_cell[a] + 32'(b) + AXIS_OFF[a];
        p1_nxt[2*a+b] = xs16(av) * MIX_C1;
      end
      tt_nxt[a] = 32'(in_frac[a]) * 32'(in_frac[a]);
      t3_nxt[a] = WGT_K3 - {1'b0, in_frac[a], 1'b0};
    end
  end

  // Stage 1: second mixer round; weight cubic product.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      p2_nxt[j] = xs15(p1_r[j]) * MIX_C2;
    end
    for (int a = 0; a < 3; a++) begin
      wp_nxt[a] = 50'(tt_r[a]) * 50'(t3_r[a]);
    end
  end

  // Stage 2: combine axes into corner hashes, start the final mix; round weights.
  always_comb begin
    logic [31:0] h;
    for (int j = 0; j < 6; j++) begin
      mm[j] = xs16(p2_r[j]);
    end
    for (int c = 0; c < 8; c++) begin
      h = salt1_r ^ mm[(c & 1)] ^ mm[2 + ((c >> 1) & 1)] ^ mm[4 + ((c >> 2) & 1)];
      q1_nxt[c] = xs16(h) * MIX_C1;
    end
    for (int a = 0; a < 3; a++) begin
      w2_nxt[a] = 17'((wp_r[a] + 50'h0_8000_0000) >> 32);
    end
  end

  // Stages 3 and 4: last mixer round and corner value.
  always_comb begin
    logic [31:0] r;
    for (int c = 0; c < 8; c++) begin
      q2_nxt[c] = xs15(q1_r[c]) * MIX_C2;
      r = xs16(q2_r[c]);
      cv_nxt[c] = cval_t'({1'b0, r[31:15]} - CVAL_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_r    <= p1_nxt;
      tt_r    <= tt_nxt;
      t3_r    <= t3_nxt;
      salt0_r <= in_salt;
      tag0_r  <= in_tag;
    end
    if (en[1]) begin
      p2_r    <= p2_nxt;
      wp_r    <= wp_nxt;
      salt1_r <= salt0_r;
      tag1_r  <= tag0_r;
    end
    if (en[2]) begin
      q1_r   <= q1_nxt;
      w2_r   <= w2_nxt;
      tag2_r <= tag1_r;
    end
    if (en[3]) begin
      q2_r   <= q2_nxt;
      w3_r   <= w2_r;
      tag3_r <= tag2_r;
    end
    if (en[4]) begin
      cv_r   <= cv_nxt;
      w4_r   <= w3_r;
      tag4_r <= tag3_r;
    end
  end

  assign out_cval = cv_r;
  assign out_wgt  = w4_r;
  assign out_tag  = tag4_r;

endmodule

@@ rtl/core/fvn_lerp.sv @@
// ----------------------------------------------------------------------------
// fvn_lerp
// Four-stage trilinear interpolation: blends the eight corner values along x,
// then y, then z, one multiply level per stage but the last, which rounds z.
// ----------------------------------------------------------------------------
module fvn_lerp import fvn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cval_t [7:0] in_cval,
  input  wgt_t  [2:0] in_wgt,
  input  tag_t        in_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output cval_t       out_val,
  output tag_t        out_tag
);

  localparam int NST = 4;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  bprod_t [3:0] px_r, px_nxt;
  cval_t  [3:0] b0_r;
  wgt_t         wy0_r, wz0_r, wz1_r;
  bprod_t [1:0] py_r, py_nxt;
  cval_t  [1:0] b1_r, b1_nxt;
  bprod_t       pz_r, pz_nxt;
  cval_t        b2_r, b2_nxt;
  cval_t        val_r, val_nxt;
  tag_t         tag0_r, tag1_r, tag2_r, tag3_r;
  cval_t  [3:0] ax;
  cval_t  [1:0] ay;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Start the x blends: corner pairs differ only in their x bit.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px_nxt[i] = mul_diff(in_cval[2*i], in_cval[2*i+1], in_wgt[0]);
    end
  end

  // Finish the x blends, then start the y blends.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ax[i] = blend_fin(b0_r[i], px_r[i]);
    end
    for (int j = 0; j < 2; j++) begin
      py_nxt[j] = mul_diff(ax[2*j], ax[2*j+1], wy0_r);
      b1_nxt[j] = ax[2*j];
    end
  end

  // Finish the y blends, start the z blend, and finish it.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ay[j] = blend_fin(b1_r[j], py_r[j]);
    end
    pz_nxt  = mul_diff(ay[0], ay[1], wz1_r);
    b2_nxt  = ay[0];
    val_nxt = blend_fin(b2_r, pz_r);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r   <= px_nxt;
      for (int i = 0; i < 4; i++) begin
        b0_r[i] <= in_cval[2*i];
      end
      wy0_r  <= in_wgt[1];
      wz0_r  <= in_wgt[2];
      tag0_r <= in_tag;
    end
    if (en[1]) begin
      py_r   <= py_nxt;
      b1_r   <= b1_nxt;
      wz1_r  <= wz0_r;
      tag1_r <= tag0_r;
    end
    if (en[2]) begin
      pz_r   <= pz_nxt;
      b2_r   <= b2_nxt;
      tag2_r <= tag1_r;
    end
    if (en[3]) begin
      val_r  <= val_nxt;
      tag3_r <= tag2_r;
    end
  end

  assign out_val = val_r;
  assign out_tag = tag3_r;

endmodule

@@ rtl/core/fvn_norm.sv @@
// ----------------------------------------------------------------------------
// fvn_norm
// Octave accumulator and normalizer. Sums the scaled octave values of one
// point, multiplies the sum by the reciprocal for its octave count, rounds,
// clamps and holds the result in the output register.
// ----------------------------------------------------------------------------
module fvn_norm import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cval_t       in_val,
  input  tag_t        in_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [17:0] out_value
);

  localparam int ACC_W  = MAX_OCTAVES + 18;
  localparam int PROD_W = ACC_W + RECIP_W + 1;
  localparam int SH     = MAX_OCTAVES - 1 + RECIP_W;
  localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) <<< (SH - 1);
  localparam logic signed [PROD_W-1:0] LIM_HI = PROD_W'(65536);
  localparam logic signed [PROD_W-1:0] LIM_LO = -LIM_HI;

  logic v0_r, v1_r, v2_r;
  logic en0, en1, en2;
  logic fire;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt, scaled, sum_r;
  logic [OCT_W-1:0]         sh_k, n0_r;
  logic                     zero0_r, zero1_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, rnd;
  logic [17:0]              res_r, res_nxt;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;
  assign fire     = in_valid && en0;

  // Scale the octave value by its amplitude and add it to the running sum.
  always_comb begin
    sh_k    = OCT_W'(MAX_OCTAVES - 1) - in_tag.k;
    scaled  = ACC_W'(in_val) <<< sh_k;
    acc_nxt = in_tag.first ? scaled : acc_r + scaled;
  end

  // Normalize by the reciprocal, then round and clamp.
  always_comb begin
    prod_nxt = PROD_W'(sum_r) * $signed({1'b0, recip(n0_r)});
    rnd      = (prod_r + HALF) >>> SH;
    if (zero1_r) begin
      res_nxt = '0;
    end else if (rnd > LIM_HI) begin
      res_nxt = LIM_HI[17:0];
    end else if (rnd < LIM_LO) begin
      res_nxt = LIM_LO[17:0];
    end else begin
      res_nxt = rnd[17:0];
    end
  end

  // Only the last octave of a point moves on to the normalizer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) begin
        v0_r <= fire && in_tag.last;
      end
      if (en1) begin
        v1_r <= v0_r;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r <= acc_nxt;
    end
    if (en0) begin
      sum_r   <= acc_nxt;
      n0_r    <= in_tag.n;
      zero0_r <= in_tag.zero;
    end
    if (en1) begin
      prod_r  <= prod_nxt;
      zero1_r <= zero0_r;
    end
    if (en2) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_value = res_r;

endmodule

@@ rtl/core/fractal_value_noise_3d_top.sv @@
// ----------------------------------------------------------------------------
// fractal_value_noise_3d_top
// Three-dimensional fractal value noise: per point, sums up to MAX_OCTAVES
// octaves of hashed, trilinearly blended lattice noise and normalizes them.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one request: a point in signed fixed point with
//   FRAC_BITS fraction bits. The out_ channel returns one result per point:
//   the noise value in signed Q1.16, clamped to minus one to one.
//   The cfg_ channel writes seed (index 0) and octave_count (index 1); it is
//   always ready. The user must see that it is written only while the block
//   is idle; the block itself does not enforce this. Each point is split
//   into octave jobs, one per octave (one job when the octave count is zero),
//   issued one per cycle while the split stage can take them, into a 13-stage
//   pipeline: split, five hash stages, four blend stages, accumulator and two
//   normalizer stages. A point holds the issue stage until its last octave job
//   issues, when the next point can already be accepted.
//   Reset clears all valid bits, sets seed to 0 and octave_count to 1.
//   When the receiver stalls, the result stays in the output register,
//   the pipeline keeps filling its empty stages, and in_ready drops once
//   the stages ahead of the issue stage are full.
// ----------------------------------------------------------------------------
module fractal_value_noise_3d_top import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_point_x,
  input  logic [31:0]          in_point_y,
  input  logic [31:0]          in_point_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [17:0]          out_noise_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int UPW = 32 + MAX_OCTAVES + FRAC_BITS;

  // Configuration registers.
  logic [31:0]      seed_r;
  logic [3:0]       octave_count_r;
  logic [OCT_W-1:0] n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r         <= '0;
      octave_count_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEED:    seed_r <= cfg_data;
        CFG_OCTAVES: octave_count_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Octave count saturated to the supported maximum.
  always_comb begin
    n_eff = {1'b0, octave_count_r};
    if (n_eff > OCT_W'(MAX_OCTAVES)) begin
      n_eff = OCT_W'(MAX_OCTAVES);
    end
  end

  // Issue stage: holds the point and steps through its octaves.
  logic             hold_v_r;
  logic [2:0][31:0] pt_r;
  logic [OCT_W-1:0] k_r;
  logic             last;
  logic             job_fire;
  logic             in_fire;
  logic             sp_en;
  logic             sp_v_r;
  logic             hash_in_ready;

  assign last     = (n_eff == '0) || (k_r == n_eff - OCT_W'(1));
  assign sp_en    = !sp_v_r || hash_in_ready;
  assign job_fire = hold_v_r && sp_en;
  assign in_ready = !hold_v_r || (job_fire && last);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      k_r      <= '0;
    end else if (in_fire) begin
      hold_v_r <= 1'b1;
      k_r      <= '0;
    end else if (job_fire) begin
      if (last) begin
        hold_v_r <= 1'b0;
      end else begin
        k_r <= k_r + OCT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt_r <= {in_point_z, in_point_y, in_point_x};
    end
  end

  // Split stage: scale by 2^k, take the lattice cell and a 16-bit fraction.
  logic [2:0][31:0] sp_cell_r, cell_nxt;
  logic [2:0][15:0] sp_frac_r, frac_nxt;
  logic [31:0]      sp_salt_r, salt_nxt;
  tag_t             sp_tag_r, tag_nxt;

  always_comb begin
    logic [UPW-1:0]         up;
    logic [FRAC_BITS+15:0]  tw;
    for (int a = 0; a < 3; a++) begin
      up          = UPW'($signed(pt_r[a])) << k_r;
      cell_nxt[a] = up[FRAC_BITS +: 32];
      tw          = {up[FRAC_BITS-1:0], 16'b0};
      frac_nxt[a] = tw[FRAC_BITS+15 -: 16];
    end
    salt_nxt      = seed_r + 32'(k_r) * SEED_STEP;
    tag_nxt.k     = k_r;
    tag_nxt.first = (k_r == '0);
    tag_nxt.last  = last;
    tag_nxt.zero  = (n_eff == '0);
    tag_nxt.n     = n_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_v_r <= 1'b0;
    end else if (sp_en) begin
      sp_v_r <= hold_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sp_en) begin
      sp_cell_r <= cell_nxt;
      sp_frac_r <= frac_nxt;
      sp_salt_r <= salt_nxt;
      sp_tag_r  <= tag_nxt;
    end
  end

  // Hash, blend and normalize pipelines.
  logic        hash_out_valid, lerp_in_ready;
  cval_t [7:0] hash_cval;
  wgt_t  [2:0] hash_wgt;
  tag_t        hash_tag;
  logic        lerp_out_valid, norm_in_ready;
  cval_t       lerp_val;
  tag_t        lerp_tag;

  fvn_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sp_v_r),
    .in_ready  (hash_in_ready),
    .in_cell   (sp_cell_r),
    .in_frac   (sp_frac_r),
    .in_salt   (sp_salt_r),
    .in_tag    (sp_tag_r),
    .out_valid (hash_out_valid),
    .out_ready (lerp_in_ready),
    .out_cval  (hash_cval),
    .out_wgt   (hash_wgt),
    .out_tag   (hash_tag)
  );

  fvn_lerp u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hash_out_valid),
    .in_ready  (lerp_in_ready),
    .in_cval   (hash_cval),
    .in_wgt    (hash_wgt),
    .in_tag    (hash_tag),
    .out_valid (lerp_out_valid),
    .out_ready (norm_in_ready),
    .out_val   (lerp_val),
    .out_tag   (lerp_tag)
  );

  fvn_norm #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lerp_out_valid),
    .in_ready  (norm_in_ready),
    .in_val    (lerp_val),
    .in_tag    (lerp_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_noise_value)
  );

`ifndef SYNTHESIS
  // A result never leaves the range minus one to one.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_noise_value) <= 18'sd65536 &&
                   $signed(out_noise_value) >= -18'sd65536))
    else $error("noise value out of range");

  // The octave counter stays below the octave count while a point is held.
  a_issue_count: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && n_eff != '0) |-> (k_r < n_eff))
    else $error("octave counter overran the octave count");

  // A job stalled in the split stage is kept, with its tag and cell unchanged.
  a_split_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_v_r && !hash_in_ready) |=> (sp_v_r && $stable(sp_tag_r) && $stable(sp_cell_r)))
    else $error("stalled split stage job was lost or changed");
`endif

endmodule

@@ tb/tb_fractal_value_noise_3d_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal value noise testbench
// Drives points and register writes into the noise block and checks each
// result against a fixed-point predictor of the octave sum, in order.
// ----------------------------------------------------------------------------

// Scoreboard: holds the predicted noise values and compares results.
class noise_scoreboard;
  logic [31:0] seed_reg;
  logic [3:0]  oct_reg;
  logic [17:0] pending[$];
  int          errors;

  function new();
    seed_reg = '0;
    oct_reg  = 4'd1;
    errors   = 0;
  endfunction

  // Avalanche mixer used on every lattice coordinate and the final hash.
  function automatic logic [31:0] mix32(logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * fvn_pkg::MIX_C1;
    v = v ^ (v >> 15);
    v = v * fvn_pkg::MIX_C2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  // Half-up rounding of v / 2^sh with an arithmetic shift.
  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint lerp(longint a, longint b, longint w);
    return a + rnd_shift((b - a) * w, 16);
  endfunction

  function automatic longint corner(logic [31:0] cx, logic [31:0] cy,
                                    logic [31:0] cz, logic [31:0] s);
    logic [31:0] h;
    h = s ^ mix32(cx + fvn_pkg::OFF_X) ^ mix32(cy + fvn_pkg::OFF_Y)
          ^ mix32(cz + fvn_pkg::OFF_Z);
    h = mix32(h);
    return longint'(h >> 15) - 65536;
  endfunction

  // Splits one scaled axis into its lattice cell and smoothstep weight.
  function automatic void split(logic [31:0] raw, int k, output logic [31:0] lat,
                                output longint w);
    logic [63:0] up, t, prod;
    up   = {{32{raw[31]}}, raw} << k;
    lat  = up[47:16];
    t    = {48'd0, up[15:0]};
    prod = t * t * (64'd196608 - 2 * t);
    w    = longint'((prod + (64'd1 << 31)) >> 32);
  endfunction

  function automatic logic [17:0] noise(logic [31:0] px, logic [31:0] py,
                                        logic [31:0] pz);
    int n;
    longint acc, res, wx, wy, wz, a00, a10, a01, a11, b0, b1;
    logic [31:0] x0, y0, z0, x1, y1, z1, s;
    n = (oct_reg > 8) ? 8 : oct_reg;
    acc = 0;
    if (n == 0) return '0;
    for (int k = 0; k < n; k++) begin
      s = seed_reg + fvn_pkg::SEED_STEP * k;
      split(px, k, x0, wx);
      split(py, k, y0, wy);
      split(pz, k, z0, wz);
      x1 = x0 + 1; y1 = y0 + 1; z1 = z0 + 1;
      a00 = lerp(corner(x0, y0, z0, s), corner(x1, y0, z0, s), wx);
      a10 = lerp(corner(x0, y1, z0, s), corner(x1, y1, z0, s), wx);
      a01 = lerp(corner(x0, y0, z1, s), corner(x1, y0, z1, s), wx);
      a11 = lerp(corner(x0, y1, z1, s), corner(x1, y1, z1, s), wx);
      b0 = lerp(a00, a10, wy);
      b1 = lerp(a01, a11, wy);
      acc += lerp(b0, b1, wz) <<< (7 - k);
    end
    res = rnd_shift(acc * longint'(fvn_pkg::recip(5'(n))), 31);
    if (res > 65536) res = 65536;
    if (res < -65536) res = -65536;
    return res[17:0];
  endfunction

  function void write_reg(logic [7:0] idx, logic [31:0] data);
    if (idx == fvn_pkg::CFG_SEED) seed_reg = data;
    else if (idx == fvn_pkg::CFG_OCTAVES) oct_reg = data[3:0];
  endfunction

  function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    pending = {pending, noise(px, py, pz)};
  endfunction

  function void check_result(logic [17:0] got);
    logic [17:0] exp_v;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, actual %0d", $time, $signed(got));
      errors++;
      return;
    end
    exp_v = pending.pop_front();
    if (got !== exp_v) begin
      $display("%0t: result mismatch, expected %0d, actual %0d", $time,
               $signed(exp_v), $signed(got));
      errors++;
    end
  endfunction
endclass

module tb_fractal_value_noise_3d_top;
  import fvn_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [17:0] out_noise_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  noise_scoreboard sb = new();
  int  hold_off = 0;      // cycles the receiver must still stall
  bit  calm_recv = 1'b0;  // receiver never idles while set
  bit  calm_send = 1'b0;

  fractal_value_noise_3d_top dut (.*);

  always #1 clk = ~clk;

  // Result side: random stalls, a forced hold-off, and the checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_noise_value);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_recv || ($urandom_range(99) >= 15);
    end
  end

  // Random idle cycles on the request side; valid drops only here and in drain.
  task automatic idle_gap();
    if (!calm_send)
      while ($urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
  endtask

  // Sends one point and waits for acceptance.
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    idle_gap();
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_point(px, py, pz);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random point: mostly small coordinates, sometimes full-range ones.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(65535 * 8)) - 262144);
      default: return $urandom_range(255) << $urandom_range(24);
    endcase
  endfunction

  task automatic random_points(int count);
    for (int i = 0; i < count; i++)
      send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0000ffff,
              32'h00010000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, field extremes, octave counts 0, 8 and 15.
    for (int i = 0; i < 6; i++) send_point(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
    drain();
    write_cfg(CFG_OCTAVES, 32'd0);
    send_point(32'h12345678, 32'h87654321, 32'hffffffff);
    drain();
    write_cfg(CFG_SEED, 32'hffffffff);
    for (int n = 8; n <= 15; n += 7) begin
      write_cfg(CFG_OCTAVES, n);
      for (int i = 0; i < 4; i++) send_point(edges[i], edges[5 - i], edges[(i + 2) % 6]);
      drain();
    end
    // Out-of-range index is ignored.
    write_cfg(8'd7, 32'd3);
    write_cfg(8'hff, 32'd0);
    send_point(32'h00018000, 32'hfffe8000, 32'h00004000);
    drain();

    // Random phases over several settings.
    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(CFG_SEED, (ph == 1) ? 32'd0 : $urandom());
      write_cfg(CFG_OCTAVES, (ph < 9) ? ph : $urandom_range(15));
      calm_send = (ph == 4);
      calm_recv = (ph == 4);
      if (ph == 6) hold_off = 300;  // let the pipeline fill and back up
      random_points(145);
      drain();  // sender waits for every result
    end
    calm_send = 0;
    calm_recv = 0;

    drain();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

@@ fractal_value_noise_3d_top.f @@
rtl/core/fvn_pkg.sv
rtl/core/fvn_hash.sv
rtl/core/fvn_lerp.sv
rtl/core/fvn_norm.sv
rtl/core/fractal_value_noise_3d_top.sv
tb/tb_fractal_value_noise_3d_top.sv
